// ----- rtl/core/rpfb_pkg.sv -----
// Package for the rotated page frame buffer plot core.
// Holds store geometry, panel defaults, operation, color and rotation codes, stage type.
// No dependencies.
package rpfb_pkg;

  localparam int unsigned PanelWidthDef  = 128;
  localparam int unsigned PanelHeightDef = 64;

  localparam int unsigned StoreDepth = 1024;
  localparam int unsigned StoreAw    = $clog2(StoreDepth);
  localparam int unsigned CoordW     = 16;
  localparam int unsigned PageBits   = 8;

  // operation codes
  localparam logic OpPlot = 1'b0;
  localparam logic OpRead = 1'b1;

  // color codes
  localparam logic [1:0] ColClear  = 2'd0;
  localparam logic [1:0] ColSet    = 2'd1;
  localparam logic [1:0] ColInvert = 2'd2;
  localparam logic [1:0] ColKeep   = 2'd3;

  // rotation codes, quarter turns
  localparam logic [1:0] Rot0   = 2'd0;
  localparam logic [1:0] Rot90  = 2'd1;
  localparam logic [1:0] Rot180 = 2'd2;
  localparam logic [1:0] Rot270 = 2'd3;

  // word in flight between the address stage and the update stage
  typedef struct packed {
    logic                valid;
    logic                op;
    logic                hit;
    logic [StoreAw-1:0]  idx;
    logic [PageBits-1:0] mask;
    logic [1:0]          colour;
  } stage_t;

endpackage

// ----- rtl/core/rotated_page_framebuffer_plot_core.sv -----
// Rotated page frame buffer plot core: monochrome page store with plot and read.
// A word is registered in the address stage, then in the result register that strobes it.
// Throughput: one word per cycle when not busy; byte read-modify-write, last write forwarded.
// Reset: rotation returns to 0; busy_o stays high while a clearing pass zeroes the store
// one byte per cycle. The receiver cannot stall results.
// Depends on rpfb_pkg.
module rotated_page_framebuffer_plot_core #(
  parameter int unsigned PanelWidth  = rpfb_pkg::PanelWidthDef,
  parameter int unsigned PanelHeight = rpfb_pkg::PanelHeightDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command side
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                opcode_i,
  input  logic signed [rpfb_pkg::CoordW-1:0]  pos_x_i,
  input  logic signed [rpfb_pkg::CoordW-1:0]  pos_y_i,
  input  logic [1:0]                          colour_i,
  input  logic [rpfb_pkg::StoreAw-1:0]        read_address_i,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_wdata_i,
  // result side
  output logic                                strobe_o,
  output logic                                in_range_o,
  output logic [rpfb_pkg::StoreAw-1:0]        byte_index_o,
  output logic [rpfb_pkg::PageBits-1:0]       byte_value_o
);
  import rpfb_pkg::*;

  // ------------------------------------------------------------------
  // Rotation register
  // ------------------------------------------------------------------
  logic [1:0] rot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q <= Rot0;
    end else if (cfg_we_i) begin
      rot_q <= cfg_wdata_i;
    end
  end

  // ------------------------------------------------------------------
  // Clearing pass after reset: walk the store writing zeros
  // ------------------------------------------------------------------
  logic               clr_busy_q, clr_busy_d;
  logic [StoreAw-1:0] clr_addr_q, clr_addr_d;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + StoreAw'(1);
      if (clr_addr_q == StoreAw'(StoreDepth - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign busy_o = clr_busy_q;

  logic accept;
  assign accept = start_i && !clr_busy_q;

  // ------------------------------------------------------------------
  // Address stage: bounds check, rotate, form byte index and bit mask
  // ------------------------------------------------------------------
  logic [CoordW-1:0] lw, lh;
  logic [CoordW-1:0] ux, uy;
  logic              pt_hit;
  logic [CoordW-1:0] px, py;
  logic [CoordW-1:0] plot_idx_full;
  logic [StoreAw-1:0] plot_idx;
  logic [PageBits-1:0] plot_mask;

  always_comb begin
    ux = pos_x_i;
    uy = pos_y_i;
    // odd rotations swap the logical bounds
    lw = rot_q[0] ? CoordW'(PanelHeight) : CoordW'(PanelWidth);
    lh = rot_q[0] ? CoordW'(PanelWidth)  : CoordW'(PanelHeight);
    pt_hit = !pos_x_i[CoordW-1] && (ux < lw) && !pos_y_i[CoordW-1] && (uy < lh);

    case (rot_q)
      Rot90: begin
        px = CoordW'(PanelWidth - 1) - uy;
        py = ux;
      end
      Rot180: begin
        px = CoordW'(PanelWidth - 1) - ux;
        py = CoordW'(PanelHeight - 1) - uy;
      end
      Rot270: begin
        px = uy;
        py = CoordW'(PanelHeight - 1) - ux;
      end
      default: begin
        px = ux;
        py = uy;
      end
    endcase

    // page row times width plus column; wraps past the store depth
    plot_idx_full = px + (py >> 3) * CoordW'(PanelWidth);
    plot_idx      = plot_idx_full[StoreAw-1:0];
    plot_mask     = PageBits'(1) << py[2:0];
  end

  stage_t s1_q, s1_d;

  always_comb begin
    s1_d        = '0;
    s1_d.valid  = accept;
    s1_d.op     = opcode_i;
    s1_d.colour = colour_i;
    s1_d.mask   = plot_mask;
    if (opcode_i == OpRead) begin
      s1_d.hit = 1'b1;
      s1_d.idx = read_address_i;
    end else begin
      s1_d.hit = pt_hit;
      s1_d.idx = plot_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q <= s1_d;
    end
  end

  // ------------------------------------------------------------------
  // Frame store: one write port, one registered read port
  // ------------------------------------------------------------------
  logic [PageBits-1:0] mem_q [StoreDepth];
  logic [PageBits-1:0] rdata_q;
  logic                mem_we;
  logic [StoreAw-1:0]  mem_waddr;
  logic [PageBits-1:0] mem_wdata;
  logic                upd_we;
  logic [PageBits-1:0] new_byte;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[s1_d.idx];
  end

  // ------------------------------------------------------------------
  // Update stage: forward the last write, apply the color, write back
  // ------------------------------------------------------------------
  logic                fwd_en_q;
  logic [StoreAw-1:0]  fwd_idx_q;
  logic [PageBits-1:0] fwd_data_q;
  logic [PageBits-1:0] old_byte;

  always_comb begin
    // the read that just landed missed a write made on the same edge
    old_byte = (fwd_en_q && fwd_idx_q == s1_q.idx) ? fwd_data_q : rdata_q;
    case (s1_q.colour)
      ColClear:  new_byte = old_byte & ~s1_q.mask;
      ColSet:    new_byte = old_byte | s1_q.mask;
      ColInvert: new_byte = old_byte ^ s1_q.mask;
      default:   new_byte = old_byte;
    endcase
    upd_we    = s1_q.valid && (s1_q.op == OpPlot) && s1_q.hit;
    mem_we    = clr_busy_q || upd_we;
    mem_waddr = clr_busy_q ? clr_addr_q : s1_q.idx;
    mem_wdata = clr_busy_q ? '0 : new_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_en_q <= 1'b0;
    end else begin
      fwd_en_q <= upd_we;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_idx_q  <= s1_q.idx;
    fwd_data_q <= new_byte;
  end

  // ------------------------------------------------------------------
  // Result register: one strobed word per accepted command
  // ------------------------------------------------------------------
  logic                strobe_q;
  logic                in_range_q;
  logic [StoreAw-1:0]  idx_q;
  logic [PageBits-1:0] val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= s1_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_q.valid) begin
      if (s1_q.op == OpRead) begin
        in_range_q <= 1'b1;
        idx_q      <= s1_q.idx;
        val_q      <= old_byte;
      end else if (s1_q.hit) begin
        in_range_q <= 1'b1;
        idx_q      <= s1_q.idx;
        val_q      <= new_byte;
      end else begin
        // off-screen plot: report nothing addressed
        in_range_q <= 1'b0;
        idx_q      <= '0;
        val_q      <= '0;
      end
    end
  end

  assign strobe_o     = strobe_q;
  assign in_range_o   = in_range_q;
  assign byte_index_o = idx_q;
  assign byte_value_o = val_q;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_result_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 strobe_o)
    else $error("result strobe missing two cycles after accept");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_q.valid |=> !strobe_o)
    else $error("result strobe without an accepted command");

  a_no_work_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !upd_we)
    else $error("store update during clearing pass");

  a_offscreen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !in_range_o) |-> (byte_index_o == '0 && byte_value_o == '0))
    else $error("off-screen result carries nonzero payload");

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for rotated_page_framebuffer_plot_core: plot and read words
// are checked against a shadow frame store kept inside the bench.
// Depends on rpfb_pkg and the core RTL.
module testbench;
  import rpfb_pkg::*;

  localparam int HalfPeriod    = 10;
  localparam int ResetCycles   = 5;
  localparam int PanelW        = int'(PanelWidthDef);
  localparam int PanelH        = int'(PanelHeightDef);
  localparam int PageW         = int'(PageBits);
  localparam int StoreMask     = int'(StoreDepth) - 1;
  localparam int NumPhases     = 8;
  localparam int WordsPerPhase = 88;
  localparam int MaxGap        = 12;
  // let the pipeline drain, with margin, before a register write
  localparam int DrainCycles   = 6;
  // covers the clearing pass after reset plus the longest sender gap, many times over
  localparam int WatchdogLimit = 4000;
  localparam int MaxReports    = 40;

  typedef struct packed {
    logic                     op;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [1:0]               colour;
    logic [StoreAw-1:0]       addr;
  } plot_word_t;

  typedef struct packed {
    logic                in_range;
    logic [StoreAw-1:0]  idx;
    logic [PageBits-1:0] val;
  } byte_result_t;

  typedef struct packed {
    plot_word_t   cmd;
    logic         typed;
    byte_result_t want;
  } directed_row_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic                       opcode_i;
  logic signed [CoordW-1:0]   pos_x_i;
  logic signed [CoordW-1:0]   pos_y_i;
  logic [1:0]                 colour_i;
  logic [StoreAw-1:0]         read_address_i;
  logic                       cfg_we_i;
  logic [1:0]                 cfg_wdata_i;
  logic                       strobe_o;
  logic                       in_range_o;
  logic [StoreAw-1:0]         byte_index_o;
  logic [PageBits-1:0]        byte_value_o;

  // shadow copy of the block: frame store and rotation register
  logic [PageBits-1:0] shadow_store [StoreDepth];
  logic [1:0]          shadow_rot;
  logic [StoreAw-1:0]  last_touched;
  int                  hot_x;
  int                  hot_y;

  byte_result_t  pending_bytes [$];
  directed_row_t directed_rows [$];
  byte_result_t  head;
  int            mismatch_count;
  int            quiet_cycles;

  rotated_page_framebuffer_plot_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .colour_i       (colour_i),
    .read_address_i (read_address_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .strobe_o       (strobe_o),
    .in_range_o     (in_range_o),
    .byte_index_o   (byte_index_o),
    .byte_value_o   (byte_value_o)
  );

  initial clk_i = 1'b0;
  always #HalfPeriod clk_i = ~clk_i;

  // Apply one accepted word to the shadow store and return the byte it yields.
  function automatic byte_result_t apply_pixel_word(plot_word_t w);
    byte_result_t        r;
    int                  lw, lh, xi, yi, px, py, idx;
    logic [PageBits-1:0] mask, b;
    r = '0;
    if (w.op == OpRead) begin
      // reads ignore coordinates and colour, store is left alone
      r.in_range = 1'b1;
      r.idx      = w.addr;
      r.val      = shadow_store[w.addr];
    end else begin
      xi = int'(w.x);
      yi = int'(w.y);
      // odd quarter turns swap the logical bounds
      lw = shadow_rot[0] ? PanelH : PanelW;
      lh = shadow_rot[0] ? PanelW : PanelH;
      if (xi >= 0 && xi < lw && yi >= 0 && yi < lh) begin
        case (shadow_rot)
          Rot90: begin
            px = PanelW - 1 - yi;
            py = xi;
          end
          Rot180: begin
            px = PanelW - 1 - xi;
            py = PanelH - 1 - yi;
          end
          Rot270: begin
            px = yi;
            py = PanelH - 1 - xi;
          end
          default: begin
            px = xi;
            py = yi;
          end
        endcase
        idx = (px + (py / PageW) * PanelW) & StoreMask;
        mask = '0;
        mask[py % PageW] = 1'b1;
        b = shadow_store[idx];
        case (w.colour)
          ColClear:  b = b & ~mask;
          ColSet:    b = b | mask;
          ColInvert: b = b ^ mask;
          default:   ;
        endcase
        shadow_store[idx] = b;
        last_touched = StoreAw'(idx);
        r.in_range = 1'b1;
        r.idx      = StoreAw'(idx);
        r.val      = b;
      end
      // out of bounds: all-zero result, nothing changes
    end
    return r;
  endfunction

  // Build one directed row; typed rows carry the result read straight off the spec.
  function automatic void add_row(logic op, int x, int y, logic [1:0] colour, int addr,
                                  logic typed, logic in_range, int idx, int val);
    directed_row_t row;
    row.cmd         = '{op, CoordW'(x), CoordW'(y), colour, StoreAw'(addr)};
    row.typed       = typed;
    row.want        = '{in_range, StoreAw'(idx), PageBits'(val)};
    directed_rows.push_back(row);
  endfunction

  // Random word, weighted toward in-range plots clustered on a few bytes so that
  // read-modify-write back to back and read-back of touched bytes are frequent.
  function automatic plot_word_t draw_random_word();
    plot_word_t w;
    int         lw, lh, pick;
    lw = shadow_rot[0] ? PanelH : PanelW;
    lh = shadow_rot[0] ? PanelW : PanelH;
    w.op     = OpPlot;
    w.x      = CoordW'($urandom);
    w.y      = CoordW'($urandom);
    w.colour = 2'($urandom);
    w.addr   = StoreAw'($urandom);
    pick = $urandom_range(99);
    if (pick < 15) begin
      w.op = OpRead;
      if ($urandom_range(1) == 1) w.addr = last_touched;
    end else if (pick < 25) begin
      // just past an edge, or anywhere in the full signed range
      case ($urandom_range(3))
        0: w.x = CoordW'(-1);
        1: w.x = CoordW'(lw);
        2: w.y = CoordW'(lh);
        default: ;
      endcase
    end else if (pick < 60) begin
      w.x = CoordW'((hot_x + $urandom_range(7)) % lw);
      w.y = CoordW'((hot_y + $urandom_range(7)) % lh);
    end else if (pick < 66) begin
      w.x = CoordW'($urandom_range(1) == 1 ? lw - 1 : 0);
      w.y = CoordW'($urandom_range(1) == 1 ? lh - 1 : 0);
    end else begin
      w.x = CoordW'($urandom_range(lw - 1));
      w.y = CoordW'($urandom_range(lh - 1));
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < MaxReports)
      $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Present one word, hold it until accepted, then queue its expected byte.
  task automatic issue_word(plot_word_t w, logic typed, byte_result_t want);
    byte_result_t r;
    opcode_i       <= w.op;
    pos_x_i        <= w.x;
    pos_y_i        <= w.y;
    colour_i       <= w.colour;
    read_address_i <= w.addr;
    start_i        <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    r = apply_pixel_word(w);
    pending_bytes.push_back(typed ? want : r);
  endtask

  // Idle the sender for a random number of cycles, with junk on the word lines.
  task automatic sender_gap(int pct);
    int n;
    n = 0;
    while (n < MaxGap && $urandom_range(99) < pct) n++;
    if (n > 0) begin
      start_i        <= 1'b0;
      opcode_i       <= 1'($urandom);
      pos_x_i        <= CoordW'($urandom);
      pos_y_i        <= CoordW'($urandom);
      colour_i       <= 2'($urandom);
      read_address_i <= StoreAw'($urandom);
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Drain the pipe, then write the rotation register.
  task automatic write_rotation(logic [1:0] rot);
    start_i <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= rot;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_rot  = rot;
  endtask

  // Result checker and watchdog. Sample at the edge; the block updates with
  // nonblocking assignments, so everything seen here is the pre-edge value.
  always @(posedge clk_i) begin
    if ((rst_ni && start_i && !busy_o) || strobe_o === 1'b1) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("FAIL rotated_page_framebuffer_plot_core");
      $finish;
    end else if (rst_ni && strobe_o !== 1'b0) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected result strobe", 32'(byte_index_o), 32'(0));
      end else begin
        head = pending_bytes.pop_front();
        if (in_range_o !== head.in_range)
          report_mismatch("in_range", 32'(in_range_o), 32'(head.in_range));
        if (byte_index_o !== head.idx)
          report_mismatch("byte_index", 32'(byte_index_o), 32'(head.idx));
        if (byte_value_o !== head.val)
          report_mismatch("byte_value", 32'(byte_value_o), 32'(head.val));
      end
    end
  end

  initial begin
    logic [1:0]   rotations [NumPhases];
    int           idle_pct [4];
    int           burst;
    byte_result_t none;

    rotations = '{Rot90, Rot270, Rot180, Rot0, Rot270, Rot90, Rot0, Rot180};
    // sender idle share per phase: none, heavy, none, moderate
    idle_pct  = '{0, 48, 0, 27};
    none      = '0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    shadow_rot     = Rot0;
    last_touched   = '0;
    hot_x          = 0;
    hot_y          = 0;
    foreach (shadow_store[i]) shadow_store[i] = '0;

    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    opcode_i       <= OpPlot;
    pos_x_i        <= '0;
    pos_y_i        <= '0;
    colour_i       <= ColClear;
    read_address_i <= '0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= Rot0;

    // Directed rows, rotation at its reset value. Typed rows: reset contents,
    // store corners, out-of-bounds and signed extremes, every colour on one
    // pixel, reads with junk coordinates and plots with junk read address.
    add_row(OpRead, 0, 0, ColClear, 0, 1, 1, 0, 0);
    add_row(OpRead, 0, 0, ColClear, StoreMask, 1, 1, StoreMask, 0);
    add_row(OpPlot, 0, 0, ColSet, 0, 1, 1, 0, 1);
    add_row(OpPlot, PanelW - 1, PanelH - 1, ColSet, 0, 1, 1, StoreMask, 128);
    add_row(OpPlot, PanelW, 0, ColSet, 0, 1, 0, 0, 0);
    add_row(OpPlot, 0, PanelH, ColSet, 0, 1, 0, 0, 0);
    add_row(OpPlot, -1, 0, ColSet, 0, 1, 0, 0, 0);
    add_row(OpPlot, 0, -1, ColSet, 0, 1, 0, 0, 0);
    add_row(OpPlot, -32768, 32767, ColSet, 0, 1, 0, 0, 0);
    add_row(OpPlot, 32767, -32768, ColInvert, StoreMask, 1, 0, 0, 0);
    add_row(OpPlot, 0, 0, ColInvert, 0, 1, 1, 0, 0);
    add_row(OpPlot, 0, 0, ColInvert, 0, 1, 1, 0, 1);
    add_row(OpPlot, 0, 0, ColKeep, 0, 1, 1, 0, 1);
    add_row(OpPlot, 0, 0, ColClear, 0, 1, 1, 0, 0);
    // same byte back to back: exercises the write forwarding path
    add_row(OpPlot, 5, 13, ColSet, 0, 0, 0, 0, 0);
    add_row(OpPlot, 5, 14, ColSet, 0, 0, 0, 0, 0);
    add_row(OpPlot, 5, 15, ColInvert, 0, 0, 0, 0, 0);
    add_row(OpPlot, 5, 13, ColClear, 0, 0, 0, 0, 0);
    add_row(OpRead, 0, 0, ColClear, 5 + PanelW, 0, 0, 0, 0);
    add_row(OpRead, -1, -1, ColKeep, StoreMask, 1, 1, StoreMask, 128);
    add_row(OpPlot, PanelW - 1, PanelH - 1, ColClear, StoreMask, 1, 1, StoreMask, 0);

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the table back to back; the first word waits out the clearing pass.
    foreach (directed_rows[i])
      issue_word(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

    // Random phases: new rotation and new hot spot each time, idle pattern cycling.
    for (int phase = 0; phase < NumPhases; phase++) begin
      write_rotation(rotations[phase]);
      hot_x = $urandom_range(PanelW - 1);
      hot_y = $urandom_range(PanelW - 1);
      burst = 0;
      for (int n = 0; n < WordsPerPhase; n++) begin
        // drop in runs of back-to-back words even in idle phases
        if (burst > 0) burst--;
        else if ($urandom_range(15) == 0) burst = $urandom_range(4, 16);
        else sender_gap(idle_pct[phase % 4]);
        issue_word(draw_random_word(), 1'b0, none);
      end
    end

    start_i <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_bytes.size() == 0) begin
      $display("PASS rotated_page_framebuffer_plot_core");
    end else begin
      $display("FAIL rotated_page_framebuffer_plot_core");
    end
    $finish;
  end

endmodule
